[hdl/ows_pkg.sv]
// shared types, constants and helpers for the owner wakeup deadline scheduler
`default_nettype none

package ows_pkg;

    localparam int OWS_OWNER_COUNT = 32;
    localparam int OWS_OWNER_W     = 5;
    localparam int OWS_TIME_W      = 32;
    localparam int OWS_MAP_W       = 32;
    localparam int OWS_IN_DATA_W   = 48;
    localparam int OWS_OUT_DATA_W  = 104;

    localparam logic [OWS_TIME_W-1:0] OWS_NO_DEADLINE = '1;

    typedef enum logic [3:0] {
        OP_SET        = 4'd0,
        OP_SET_WAKE   = 4'd1,
        OP_CLEAR      = 4'd2,
        OP_WAIT_RES   = 4'd3,
        OP_RES_AVAIL  = 4'd4,
        OP_SNAPSHOT   = 4'd5,
        OP_SCHED_MS   = 4'd6,
        OP_CLR_MS     = 4'd7,
        OP_NEXT_MS    = 4'd8,
        OP_SCHED_SMP  = 4'd9,
        OP_SAMPLE_EVT = 4'd10,
        OP_INIT       = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic scan_step;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

    // wrap-safe: a lies before b
    function automatic logic time_before(input logic [OWS_TIME_W-1:0] a,
                                         input logic [OWS_TIME_W-1:0] b);
        logic [OWS_TIME_W-1:0] diff;
        diff = a - b;
        return diff[OWS_TIME_W-1];
    endfunction

endpackage

`default_nettype wire

[hdl/ows_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module ows_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/ows_ctrl.sv]
// sequencing state machine of the owner wakeup deadline scheduler
`default_nettype none

module ows_ctrl
    import ows_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stat.scan_last) |=> (state_reg == ST_FINISH))
        else $error("scan did not end after the last entry");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_READ))
        else $error("accepted word did not start an entry read");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !stat.out_free) |=> (state_reg == ST_DONE))
        else $error("result left done state while output slot busy");

endmodule

`default_nettype wire

[hdl/ows_datapath.sv]
// bitmaps, deadline tables, scan unit and result register
`default_nettype none

module ows_datapath
    import ows_pkg::*;
#(
    parameter int OWNER_COUNT = OWS_OWNER_COUNT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output stat_t                          stat,
    input  wire logic [OWS_IN_DATA_W-1:0]  in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [OWS_OUT_DATA_W-1:0] out_data
);

    localparam int IDX_W = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
    localparam int CNT_W = $clog2(OWNER_COUNT + 1);

    // current word
    op_t                   op_reg,  op_next;
    logic [OWS_OWNER_W-1:0] own_reg, own_next;
    logic [OWS_TIME_W-1:0]  tv_reg,  tv_next;

    // architectural state
    logic [OWS_MAP_W-1:0]   runnable_reg, runnable_next;
    logic [OWS_MAP_W-1:0]   waiting_reg,  waiting_next;
    logic [OWNER_COUNT-1:0] ms_vld_reg,   ms_vld_next;
    logic [OWNER_COUNT-1:0] smp_vld_reg,  smp_vld_next;
    logic [OWS_TIME_W-1:0]  esw_reg,      esw_next;

    // scan unit
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic                   proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]       proc_idx_reg, proc_idx_next;
    logic [OWS_TIME_W-1:0]  best_ms_reg,  best_ms_next;
    logic [OWS_TIME_W-1:0]  best_smp_reg, best_smp_next;
    logic                   woke_reg,     woke_next;
    logic                   wake_reg,     wake_next;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic [OWS_OUT_DATA_W-1:0] m_data_reg,  m_data_next;

    logic                   own_ok;
    logic [IDX_W-1:0]       oidx;
    logic [OWS_MAP_W-1:0]   own_bit;
    logic [OWS_MAP_W-1:0]   proc_bit;
    logic [IDX_W-1:0]       raddr;
    logic [OWS_TIME_W-1:0]  ms_rdata;
    logic [OWS_TIME_W-1:0]  smp_rdata;
    logic [OWS_TIME_W-1:0]  ms_cur;
    logic [OWS_TIME_W-1:0]  smp_cur;
    logic                   ms_we;
    logic                   smp_we;
    logic                   found;
    logic                   own_run;

    assign own_ok   = {1'b0, own_reg} < (OWS_OWNER_W + 1)'(OWNER_COUNT);
    assign oidx     = IDX_W'(own_reg);
    assign own_bit  = OWS_MAP_W'(1) << own_reg;
    assign proc_bit = OWS_MAP_W'(1) << proc_idx_reg;
    assign raddr    = cmd.scan_step ? cnt_reg[IDX_W-1:0] : oidx;

    // entries without a valid bit read as no deadline
    always_comb
    begin
        if (cmd.update)
        begin
            ms_cur  = ms_vld_reg[oidx]  ? ms_rdata  : OWS_NO_DEADLINE;
            smp_cur = smp_vld_reg[oidx] ? smp_rdata : OWS_NO_DEADLINE;
        end
        else
        begin
            ms_cur  = ms_vld_reg[proc_idx_reg]  ? ms_rdata  : OWS_NO_DEADLINE;
            smp_cur = smp_vld_reg[proc_idx_reg] ? smp_rdata : OWS_NO_DEADLINE;
        end
    end

    assign ms_we  = cmd.update && op_reg == OP_SCHED_MS && own_ok &&
                    (ms_cur == OWS_NO_DEADLINE || time_before(tv_reg, ms_cur));
    assign smp_we = cmd.update && op_reg == OP_SCHED_SMP && own_ok &&
                    (smp_cur == OWS_NO_DEADLINE || time_before(tv_reg, smp_cur));

    ows_ram #(
        .WIDTH (OWS_TIME_W),
        .DEPTH (OWNER_COUNT)
    ) u_ms_ram (
        .clk   (clk),
        .we    (ms_we),
        .waddr (oidx),
        .wdata (tv_reg),
        .raddr (raddr),
        .rdata (ms_rdata)
    );

    ows_ram #(
        .WIDTH (OWS_TIME_W),
        .DEPTH (OWNER_COUNT)
    ) u_smp_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (oidx),
        .wdata (tv_reg),
        .raddr (raddr),
        .rdata (smp_rdata)
    );

    assign found   = (op_reg == OP_NEXT_MS) && (best_ms_reg != OWS_NO_DEADLINE);
    assign own_run = own_ok && runnable_reg[own_reg];

    always_comb
    begin
        op_next       = op_reg;
        own_next      = own_reg;
        tv_next       = tv_reg;
        runnable_next = runnable_reg;
        waiting_next  = waiting_reg;
        ms_vld_next   = ms_vld_reg;
        smp_vld_next  = smp_vld_reg;
        esw_next      = esw_reg;
        cnt_next      = cnt_reg;
        proc_vld_next = 1'b0;
        proc_idx_next = proc_idx_reg;
        best_ms_next  = best_ms_reg;
        best_smp_next = best_smp_reg;
        woke_next     = woke_reg;
        wake_next     = wake_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (cmd.accept)
        begin
            op_next  = op_t'(in_data[3:0]);
            own_next = in_data[8:4];
            tv_next  = in_data[40:9];
        end

        if (cmd.update)
        begin
            cnt_next      = '0;
            best_ms_next  = OWS_NO_DEADLINE;
            best_smp_next = OWS_NO_DEADLINE;
            woke_next     = 1'b0;
            wake_next     = 1'b0;
            unique case (op_reg)
                OP_SET:
                begin
                    if (own_ok)
                    begin
                        runnable_next = runnable_reg | own_bit;
                    end
                end
                OP_SET_WAKE:
                begin
                    if (own_ok)
                    begin
                        runnable_next = runnable_reg | own_bit;
                        wake_next     = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    if (own_ok)
                    begin
                        runnable_next = runnable_reg & ~own_bit;
                    end
                end
                OP_WAIT_RES:
                begin
                    if (own_ok)
                    begin
                        runnable_next = runnable_reg & ~own_bit;
                        waiting_next  = waiting_reg | own_bit;
                    end
                end
                OP_RES_AVAIL:
                begin
                    runnable_next = runnable_reg | waiting_reg;
                    waiting_next  = '0;
                    wake_next     = |waiting_reg;
                end
                OP_SCHED_MS:
                begin
                    if (ms_we)
                    begin
                        ms_vld_next[oidx] = 1'b1;
                    end
                end
                OP_CLR_MS:
                begin
                    if (own_ok)
                    begin
                        ms_vld_next[oidx] = 1'b0;
                    end
                end
                OP_SCHED_SMP:
                begin
                    if (smp_we)
                    begin
                        smp_vld_next[oidx] = 1'b1;
                        if (esw_reg == OWS_NO_DEADLINE || time_before(tv_reg, esw_reg))
                        begin
                            esw_next = tv_reg;
                        end
                    end
                end
                OP_INIT:
                begin
                    runnable_next = '0;
                    waiting_next  = '0;
                    ms_vld_next   = '0;
                    smp_vld_next  = '0;
                    esw_next      = OWS_NO_DEADLINE;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            cnt_next      = cnt_reg + CNT_W'(1);
            proc_vld_next = cnt_reg < CNT_W'(OWNER_COUNT);
            proc_idx_next = cnt_reg[IDX_W-1:0];
        end

        // one ms entry and one sample entry per cycle
        if (proc_vld_reg)
        begin
            if (ms_cur != OWS_NO_DEADLINE)
            begin
                if (op_reg == OP_SNAPSHOT && !time_before(tv_reg, ms_cur))
                begin
                    ms_vld_next[proc_idx_reg] = 1'b0;
                    runnable_next             = runnable_next | proc_bit;
                end
                else if (best_ms_reg == OWS_NO_DEADLINE ||
                         time_before(ms_cur, best_ms_reg))
                begin
                    best_ms_next = ms_cur;
                end
            end
            if (smp_cur != OWS_NO_DEADLINE)
            begin
                if (op_reg == OP_SAMPLE_EVT && !time_before(tv_reg, smp_cur))
                begin
                    smp_vld_next[proc_idx_reg] = 1'b0;
                    runnable_next              = runnable_next | proc_bit;
                    woke_next                  = 1'b1;
                end
                else if (best_smp_reg == OWS_NO_DEADLINE ||
                         time_before(smp_cur, best_smp_reg))
                begin
                    best_smp_next = smp_cur;
                end
            end
        end

        if (cmd.finish && op_reg == OP_SAMPLE_EVT && woke_reg)
        begin
            esw_next  = best_smp_reg;
            wake_next = 1'b1;
        end

        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0, wake_reg, esw_reg, best_ms_reg, found, own_ok, own_run,
                            runnable_reg};
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runnable_reg <= '0;
            waiting_reg  <= '0;
            ms_vld_reg   <= '0;
            smp_vld_reg  <= '0;
            esw_reg      <= OWS_NO_DEADLINE;
            proc_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            runnable_reg <= runnable_next;
            waiting_reg  <= waiting_next;
            ms_vld_reg   <= ms_vld_next;
            smp_vld_reg  <= smp_vld_next;
            esw_reg      <= esw_next;
            proc_vld_reg <= proc_vld_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        own_reg      <= own_next;
        tv_reg       <= tv_next;
        proc_idx_reg <= proc_idx_next;
        best_ms_reg  <= best_ms_next;
        best_smp_reg <= best_smp_next;
        woke_reg     <= woke_next;
        wake_reg     <= wake_next;
        m_data_reg   <= m_data_next;
    end

    assign stat.scan_last = cnt_reg == CNT_W'(OWNER_COUNT);
    assign stat.out_free  = !m_valid_reg || out_ready;
    assign out_valid      = m_valid_reg;
    assign out_data       = m_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || out_ready))
        else $error("result register overwritten before taken");

    a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept || cmd.out_load) |-> !proc_vld_reg)
        else $error("scan entry processed outside a scan");

    a_vld_change: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.update && !proc_vld_reg) |=> $stable(ms_vld_reg) && $stable(smp_vld_reg))
        else $error("deadline valid bits changed outside update or scan");

endmodule

`default_nettype wire

[hdl/owner_wakeup_deadline_scheduler.sv]
// top level of the owner wakeup deadline scheduler
//
// one word in on s_axis gives one word out on m_axis; each word is one
// operation on the per-owner runnable and waiting bitmaps and the ms and
// sample deadline tables, and the result reports the state afterwards
// (runnable map, addressed owner bits, earliest ms deadline, earliest
// sample wake, wake pulse)
// a word passes through one table read, one update, a scan that walks
// both deadline tables one entry per cycle through the registered ram
// read, a finish step and the result load, which waits until the output
// slot is free; the next word is taken once the result has been loaded
// one word is in work at a time; s_axis_tready is high only while idle
// a result waiting on a stalled m_axis does not block the next accept,
// the block then holds its finished next result until the slot empties
// reset clears the bitmaps, marks all deadlines empty and sets the
// earliest sample wake to all ones; no clearing pass is needed
`default_nettype none

module owner_wakeup_deadline_scheduler
    import ows_pkg::*;
#(
    parameter int OWNER_COUNT = OWS_OWNER_COUNT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode, owner, time_value, zero fill
    input  wire logic [OWS_IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // runnable_map, owner_runnable, owner_valid, deadline_found,
    // next_deadline, next_sample_wake, wake_pulse, zero fill
    output logic      [OWS_OUT_DATA_W-1:0] m_axis_tdata
);

    cmd_t  cmd;
    stat_t stat;

    ows_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ows_datapath #(
        .OWNER_COUNT (OWNER_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking stream testbench for the owner wakeup deadline scheduler
module tb_top;
    import ows_pkg::*;

    localparam logic [3:0] OPC_SPARE_FIRST = 4'd12;
    localparam logic [3:0] OPC_SPARE_LAST  = 4'd15;
    localparam int         MAX_GAP         = 5;
    localparam int         LONG_HOLD       = 400;
    localparam int         RANDOM_OPS      = 700;

    // opcode, owner, time_value, zero fill
    typedef struct packed {
        logic [6:0]            pad;
        logic [OWS_TIME_W-1:0] tv;
        logic [OWS_OWNER_W-1:0] owner;
        logic [3:0]            opc;
    } sched_cmd_t;

    // runnable_map, owner_runnable, owner_valid, deadline_found,
    // next_deadline, next_sample_wake, wake_pulse, zero fill
    typedef struct packed {
        logic [3:0]            pad;
        logic                  wake;
        logic [OWS_TIME_W-1:0] smp_wake;
        logic [OWS_TIME_W-1:0] next_ms;
        logic                  found;
        logic                  valid;
        logic                  run;
        logic [OWS_MAP_W-1:0]  map;
    } sched_status_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic [OWS_IN_DATA_W-1:0]  s_tdata = '0;
    logic                      s_tready;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OWS_OUT_DATA_W-1:0] m_tdata;

    logic [OWS_MAP_W-1:0]  run_map;
    logic [OWS_MAP_W-1:0]  wait_map;
    logic [OWS_TIME_W-1:0] ms_due [OWS_OWNER_COUNT];
    logic [OWS_TIME_W-1:0] sample_due [OWS_OWNER_COUNT];
    logic [OWS_TIME_W-1:0] sample_wake;

    sched_status_t         pending_status [$];
    logic [OWS_TIME_W-1:0] clock_now;
    bit                    idle_on = 1'b1;
    int                    rx_hold_cycles = 0;
    int                    fail_count = 0;
    int                    checked_count = 0;
    int                    wake_count = 0;
    int                    found_count = 0;
    int                    op_count [16];

    owner_wakeup_deadline_scheduler #(
        .OWNER_COUNT(OWS_OWNER_COUNT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending_status.size());
        $display("*** FAILED ***");
        $finish;
    end

    // wrap-safe ordering of two times
    function automatic logic is_earlier(input logic [OWS_TIME_W-1:0] a,
                                        input logic [OWS_TIME_W-1:0] b);
        logic [OWS_TIME_W-1:0] delta;
        delta = a - b;
        return delta[OWS_TIME_W-1];
    endfunction

    function automatic void clear_scheduler();
        int i;
        run_map     = '0;
        wait_map    = '0;
        sample_wake = OWS_NO_DEADLINE;
        for (i = 0; i < OWS_OWNER_COUNT; i++)
        begin
            ms_due[i]     = OWS_NO_DEADLINE;
            sample_due[i] = OWS_NO_DEADLINE;
        end
    endfunction

    function automatic logic [OWS_TIME_W-1:0] earliest_deadline(input logic from_sample);
        logic [OWS_TIME_W-1:0] best;
        logic [OWS_TIME_W-1:0] d;
        int i;
        best = OWS_NO_DEADLINE;
        for (i = 0; i < OWS_OWNER_COUNT; i++)
        begin
            d = from_sample ? sample_due[i] : ms_due[i];
            if (d != OWS_NO_DEADLINE && (best == OWS_NO_DEADLINE || is_earlier(d, best)))
                best = d;
        end
        return best;
    endfunction

    function automatic sched_status_t predict_status(input sched_cmd_t cmd);
        sched_status_t st;
        logic [OWS_MAP_W-1:0] sel;
        logic [OWS_MAP_W-1:0] waiters;
        logic ok;
        logic woke;
        logic expired;
        int i;
        st      = '0;
        ok      = int'(cmd.owner) < OWS_OWNER_COUNT;
        sel     = {{(OWS_MAP_W-1){1'b0}}, 1'b1} << cmd.owner;
        woke    = 1'b0;
        expired = 1'b0;
        case (cmd.opc)
            OP_SET:
                if (ok) run_map |= sel;
            OP_SET_WAKE:
                if (ok)
                begin
                    run_map |= sel;
                    woke = 1'b1;
                end
            OP_CLEAR:
                if (ok) run_map &= ~sel;
            OP_WAIT_RES:
                if (ok)
                begin
                    run_map  &= ~sel;
                    wait_map |= sel;
                end
            OP_RES_AVAIL:
            begin
                waiters  = wait_map;
                wait_map = '0;
                run_map |= waiters;
                woke     = waiters != '0;
            end
            OP_SNAPSHOT:
                for (i = 0; i < OWS_OWNER_COUNT; i++)
                    if (ms_due[i] != OWS_NO_DEADLINE && !is_earlier(cmd.tv, ms_due[i]))
                    begin
                        ms_due[i]  = OWS_NO_DEADLINE;
                        run_map[i] = 1'b1;
                    end
            OP_SCHED_MS:
                if (ok && (ms_due[cmd.owner] == OWS_NO_DEADLINE ||
                           is_earlier(cmd.tv, ms_due[cmd.owner])))
                    ms_due[cmd.owner] = cmd.tv;
            OP_CLR_MS:
                if (ok) ms_due[cmd.owner] = OWS_NO_DEADLINE;
            OP_SCHED_SMP:
                if (ok && (sample_due[cmd.owner] == OWS_NO_DEADLINE ||
                           is_earlier(cmd.tv, sample_due[cmd.owner])))
                begin
                    sample_due[cmd.owner] = cmd.tv;
                    if (sample_wake == OWS_NO_DEADLINE || is_earlier(cmd.tv, sample_wake))
                        sample_wake = cmd.tv;
                end
            OP_SAMPLE_EVT:
            begin
                for (i = 0; i < OWS_OWNER_COUNT; i++)
                    if (sample_due[i] != OWS_NO_DEADLINE && !is_earlier(cmd.tv, sample_due[i]))
                    begin
                        sample_due[i] = OWS_NO_DEADLINE;
                        run_map[i]    = 1'b1;
                        expired       = 1'b1;
                    end
                if (expired)
                begin
                    sample_wake = earliest_deadline(1'b1);
                    woke        = 1'b1;
                end
            end
            OP_INIT:
                clear_scheduler();
            default:
                ;
        endcase
        st.map      = run_map;
        st.run      = ok && run_map[cmd.owner];
        st.valid    = ok;
        st.next_ms  = earliest_deadline(1'b0);
        st.found    = (cmd.opc == OP_NEXT_MS) && (st.next_ms != OWS_NO_DEADLINE);
        st.smp_wake = sample_wake;
        st.wake     = woke;
        return st;
    endfunction

    // each call returns right after the edge at which the word was taken
    task automatic issue_op(input logic [3:0] opc, input logic [OWS_OWNER_W-1:0] owner,
                            input logic [OWS_TIME_W-1:0] tv);
        sched_cmd_t cmd;
        int gap;
        cmd       = '0;
        cmd.opc   = opc;
        cmd.owner = owner;
        cmd.tv    = tv;
        gap       = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cmd;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        op_count[opc]++;
        pending_status.push_back(predict_status(cmd));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [OWS_TIME_W-1:0] pick_deadline();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return OWS_NO_DEADLINE;
            2:       return clock_now - $urandom_range(0, 20);
            default: return clock_now + $urandom_range(0, 120);
        endcase
    endfunction

    task automatic issue_random_op();
        int pick;
        logic [OWS_OWNER_W-1:0] owner;
        logic [OWS_TIME_W-1:0] tv;
        pick  = $urandom_range(0, 99);
        owner = OWS_OWNER_W'($urandom_range(0, 31));
        tv    = $urandom;
        if ($urandom_range(0, 199) == 0)
            clock_now = 32'hFFFF_FF80;
        if (pick < 8)
            issue_op(OP_SET, owner, tv);
        else if (pick < 14)
            issue_op(OP_SET_WAKE, owner, tv);
        else if (pick < 22)
            issue_op(OP_CLEAR, owner, tv);
        else if (pick < 30)
            issue_op(OP_WAIT_RES, owner, tv);
        else if (pick < 36)
            issue_op(OP_RES_AVAIL, owner, tv);
        else if (pick < 46)
        begin
            clock_now += $urandom_range(0, 40);
            issue_op(OP_SNAPSHOT, owner, ($urandom_range(0, 9) == 0) ? tv : clock_now);
        end
        else if (pick < 60)
            issue_op(OP_SCHED_MS, owner, pick_deadline());
        else if (pick < 65)
            issue_op(OP_CLR_MS, owner, tv);
        else if (pick < 72)
            issue_op(OP_NEXT_MS, owner, tv);
        else if (pick < 84)
            issue_op(OP_SCHED_SMP, owner, pick_deadline());
        else if (pick < 94)
        begin
            clock_now += $urandom_range(0, 40);
            issue_op(OP_SAMPLE_EVT, owner, ($urandom_range(0, 9) == 0) ? tv : clock_now);
        end
        else if (pick < 96)
            issue_op(OP_INIT, owner, tv);
        else
            issue_op(4'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST)), owner, tv);
    endtask

    task automatic compare_field(input string name, input logic [OWS_TIME_W-1:0] want,
                                 input logic [OWS_TIME_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_status(input logic [OWS_OUT_DATA_W-1:0] data);
        sched_status_t got;
        sched_status_t want;
        got = sched_status_t'(data);
        if (pending_status.size() == 0)
        begin
            fail_count++;
            $display("%0t: result word with nothing expected, expected none, got %h",
                     $time, data);
        end
        else
        begin
            want = pending_status.pop_front();
            compare_field("runnable_map", want.map, got.map);
            compare_field("owner_runnable", OWS_TIME_W'(want.run), OWS_TIME_W'(got.run));
            compare_field("owner_valid", OWS_TIME_W'(want.valid), OWS_TIME_W'(got.valid));
            compare_field("deadline_found", OWS_TIME_W'(want.found), OWS_TIME_W'(got.found));
            compare_field("next_deadline", want.next_ms, got.next_ms);
            compare_field("next_sample_wake", want.smp_wake, got.smp_wake);
            compare_field("wake_pulse", OWS_TIME_W'(want.wake), OWS_TIME_W'(got.wake));
            checked_count++;
            wake_count  += int'(want.wake);
            found_count += int'(want.found);
        end
    endtask

    initial
    begin : result_monitor
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            check_status(m_tdata);
        end
    end

    task automatic test_bitmap_ops();
        issue_op(OP_SET, 5'd0, 32'h0000_0000);
        issue_op(OP_SET_WAKE, 5'd31, 32'hFFFF_FFFF);
        // wake again with the bit already set
        issue_op(OP_SET_WAKE, 5'd31, 32'h0000_0000);
        issue_op(OP_CLEAR, 5'd0, 32'hFFFF_FFFF);
        issue_op(OP_CLEAR, 5'd5, 32'h8000_0000);
        wait_all_results();
    endtask

    task automatic test_resource_wait();
        issue_op(OP_WAIT_RES, 5'd31, 32'h0);
        issue_op(OP_WAIT_RES, 5'd7, 32'h0);
        issue_op(OP_RES_AVAIL, 5'd0, 32'h0);
        // no waiters left, so no wake
        issue_op(OP_RES_AVAIL, 5'd7, 32'h0);
        wait_all_results();
    endtask

    task automatic test_ms_deadlines();
        issue_op(OP_NEXT_MS, 5'd0, 32'h0);
        issue_op(OP_SCHED_MS, 5'd3, 32'd100);
        issue_op(OP_SCHED_MS, 5'd3, 32'd200);
        // equal deadlines on two owners
        issue_op(OP_SCHED_MS, 5'd9, 32'd100);
        // lies before 100 across the wrap
        issue_op(OP_SCHED_MS, 5'd12, 32'hFFFF_FFF0);
        issue_op(OP_NEXT_MS, 5'd12, 32'h0);
        // all ones is earlier than 100 and clears the entry
        issue_op(OP_SCHED_MS, 5'd3, OWS_NO_DEADLINE);
        issue_op(OP_CLR_MS, 5'd9, 32'h0);
        issue_op(OP_SNAPSHOT, 5'd12, 32'hFFFF_FFF8);
        issue_op(OP_NEXT_MS, 5'd31, 32'h0);
        wait_all_results();
    endtask

    task automatic test_sample_deadlines();
        issue_op(OP_SCHED_SMP, 5'd4, 32'd50);
        issue_op(OP_SCHED_SMP, 5'd20, 32'd30);
        issue_op(OP_SCHED_SMP, 5'd4, 32'd60);
        issue_op(OP_SAMPLE_EVT, 5'd20, 32'd40);
        issue_op(OP_SAMPLE_EVT, 5'd4, 32'd45);
        wait_all_results();
    endtask

    task automatic test_spare_and_init();
        issue_op(OPC_SPARE_FIRST, 5'd31, 32'hFFFF_FFFF);
        issue_op(OPC_SPARE_LAST, 5'd0, 32'h0);
        issue_op(OP_INIT, 5'd17, 32'h5555_AAAA);
        wait_all_results();
    endtask

    task automatic test_random_ops();
        int k;
        clock_now = $urandom;
        for (k = 0; k < RANDOM_OPS; k++)
        begin
            // every third stretch runs with no idling on either side
            idle_on = ((k / 100) % 3) != 1;
            if (k == RANDOM_OPS / 2)
                clock_now = 32'hFFFF_FE00;
            issue_random_op();
        end
        wait_all_results();
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        idle_on        = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        repeat (25) issue_random_op();
        wait_all_results();
        idle_on = 1'b1;
    endtask

    initial
    begin : stimulus
        int covered;
        int i;
        covered = 0;
        for (i = 0; i < 16; i++)
            op_count[i] = 0;
        clear_scheduler();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bitmap_ops();
        test_resource_wait();
        test_ms_deadlines();
        test_sample_deadlines();
        test_spare_and_init();
        test_random_ops();
        test_output_stall();
        wait_all_results();
        repeat (OWS_OWNER_COUNT + 16) @(posedge clk);
        for (i = 0; i < 16; i++)
            if (op_count[i] > 0)
                covered++;
        $display("covered %0d of 16 opcode codes, %0d result words checked", covered,
                 checked_count);
        $display("%0d wake pulses and %0d found deadlines seen", wake_count, found_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
